/* sv/dq_pkg.sv */
// dq_pkg: shared types and codes for the double-ended queue
// no dependencies

package dq_pkg;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_status;

    localparam t_action ACT_PUSH_FRONT = 2'd0;
    localparam t_action ACT_PUSH_BACK  = 2'd1;
    localparam t_action ACT_POP_FRONT  = 2'd2;
    localparam t_action ACT_POP_BACK   = 2'd3;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;

    localparam int PORT_VALUE_BITS = 32;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } t_cell_ctl;

endpackage

/* sv/dq_if.sv */
// dq_req_if / dq_rsp_if: valid-ready channels for requests and results
// depends on dq_pkg

interface dq_req_if;
    logic                                        valid;
    logic                                        ready;
    dq_pkg::t_action                             action;
    logic signed [dq_pkg::PORT_VALUE_BITS-1:0]   push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface dq_rsp_if #(
    parameter int CNT_W = 5
);
    logic                                        valid;
    logic                                        ready;
    dq_pkg::t_status                             status;
    logic signed [dq_pkg::PORT_VALUE_BITS-1:0]   front_value;
    logic signed [dq_pkg::PORT_VALUE_BITS-1:0]   back_value;
    logic [CNT_W-1:0]                            element_count;
    logic                                        is_empty;

    modport source (output valid, output status, output front_value, output back_value,
                    output element_count, output is_empty, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input element_count, input is_empty, output ready);
endinterface

/* sv/dq_cell.sv */
// dq_cell: one storage cell of the deque chain, shifts with its neighbors
// depends on dq_pkg

module dq_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dq_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_BITS-1:0] i_push_value,
    input  logic [VALUE_BITS-1:0] i_prev_value,
    input  logic                  i_prev_valid,
    input  logic [VALUE_BITS-1:0] i_next_value,
    input  logic                  i_next_valid,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_back_value
);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  r_valid;
    logic                  n_valid;
    logic                  w_last;
    logic                  w_slot;

    assign w_last = r_valid && !i_next_valid;
    assign w_slot = !r_valid && i_prev_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.push_front) begin
            n_value = i_prev_value;
            n_valid = i_prev_valid;
        end else if (i_ctl.pop_front) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctl.push_back && w_slot) begin
            n_value = i_push_value;
            n_valid = 1'b1;
        end else if (i_ctl.pop_back && w_last) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_valid      = r_valid;
    assign o_back_value = w_last ? r_value : '0;

endmodule

/* sv/double_ended_queue_top.sv */
// double_ended_queue_top: bounded deque as a shifting chain of CAPACITY cells
// result via pending then result register; one item per cycle sustained
// while o_rsp is ready, set by the single cell update per request
// and the result register; synchronous active-low reset empties the chain
// no clearing pass; depends on dq_pkg, dq_if, dq_cell

module double_ended_queue_top #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dq_req_if.sink      i_req,
    dq_rsp_if.source    o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = dq_pkg::PORT_VALUE_BITS;

    logic [VALUE_BITS-1:0] w_value [CAPACITY];
    logic [VALUE_BITS-1:0] w_backm [CAPACITY];
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_col   [VALUE_BITS];
    logic [VALUE_BITS-1:0] w_back_store;
    logic signed [VALUE_BITS-1:0] w_front_s;
    logic signed [VALUE_BITS-1:0] w_back_s;
    logic signed [VALUE_BITS-1:0] w_push_store;

    logic              w_accept;
    logic              w_load;
    logic              w_full;
    logic              w_empty;
    logic              w_is_push;
    dq_pkg::t_cell_ctl w_ctl;
    dq_pkg::t_status   w_status;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_pend;
    dq_pkg::t_status   r_pend_status;
    logic              r_out_valid;
    dq_pkg::t_status   r_status;
    logic [PW-1:0]     r_front;
    logic [PW-1:0]     r_back;
    logic [CNT_W-1:0]  r_count_out;
    logic              r_empty;

    assign w_push_store = VALUE_BITS'(i_req.push_value);

    assign w_load   = r_pend && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_pend || w_load;
    assign w_accept = i_req.valid && i_req.ready;

    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_is_push = (i_req.action == dq_pkg::ACT_PUSH_FRONT) ||
                       (i_req.action == dq_pkg::ACT_PUSH_BACK);

    always_comb begin
        w_ctl    = '0;
        w_status = dq_pkg::ST_DONE;
        n_count  = r_count;
        if (w_is_push && w_full) begin
            w_status = dq_pkg::ST_OVERFLOW;
        end else if (!w_is_push && w_empty) begin
            w_status = dq_pkg::ST_UNDERFLOW;
        end else if (w_accept) begin
            case (i_req.action)
                dq_pkg::ACT_PUSH_FRONT: w_ctl.push_front = 1'b1;
                dq_pkg::ACT_PUSH_BACK:  w_ctl.push_back  = 1'b1;
                dq_pkg::ACT_POP_FRONT:  w_ctl.pop_front  = 1'b1;
                dq_pkg::ACT_POP_BACK:   w_ctl.pop_back   = 1'b1;
                default:                w_ctl            = '0;
            endcase
            n_count = w_is_push ? r_count + 1'b1 : r_count - 1'b1;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_prev_value;
        logic                  w_prev_valid;
        logic [VALUE_BITS-1:0] w_next_value;
        logic                  w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_value = w_push_store;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_value = w_value[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_value = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_body
            assign w_next_value = w_value[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        dq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_push_value (w_push_store),
            .i_prev_value (w_prev_value),
            .i_prev_valid (w_prev_valid),
            .i_next_value (w_next_value),
            .i_next_valid (w_next_valid),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g]),
            .o_back_value (w_backm[g])
        );
    end

    // back value: only the last valid cell drives a nonzero word
    for (genvar b = 0; b < VALUE_BITS; b++) begin : g_col
        for (genvar c = 0; c < CAPACITY; c++) begin : g_row
            assign w_col[b][c] = w_backm[c][b];
        end
        assign w_back_store[b] = |w_col[b];
    end

    assign w_front_s = w_valid[0] ? w_value[0] : '0;
    assign w_back_s  = w_back_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= w_status;
        end
        if (w_load) begin
            r_status    <= r_pend_status;
            r_front     <= PW'(w_front_s);
            r_back      <= PW'(w_back_s);
            r_count_out <= r_count;
            r_empty     <= w_empty;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.front_value   = r_front;
    assign o_rsp.back_value    = r_back;
    assign o_rsp.element_count = r_count_out;
    assign o_rsp.is_empty      = r_empty;

`ifndef SYNTHESIS
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with count");

    a_front_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] == (r_count != '0))
        else $error("front cell valid disagrees with count");

    a_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_pend)
        else $error("accepted item left no pending result");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status == dq_pkg::ST_OVERFLOW) |-> r_count == CNT_W'(CAPACITY))
        else $error("overflow reported while not full");
`endif

endmodule
